// ===== sv/rebd_pkg.sv =====
// ----------------------------------------------------------------------------
// rebd_pkg
// Types and constants shared by the rotary encoder and button decoder.
// ----------------------------------------------------------------------------
package rebd_pkg;

  // Result codes
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CW    = 3'd1,
    EV_CCW   = 3'd2,
    EV_CLICK = 3'd3,
    EV_LONG  = 3'd4
  } event_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_LONG_PRESS_MS  = 2'd0;
  localparam logic [1:0] CFG_ENC_HOLDOFF_US = 2'd1;
  localparam logic [1:0] CFG_BTN_SETTLE_MS  = 2'd2;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd1000;
  localparam logic [15:0] ENC_HOLDOFF_US_RST = 16'd800;
  localparam logic [7:0]  BTN_SETTLE_MS_RST  = 8'd25;

  // Quadrature transition table, indexed by {previous phase, current phase}
  localparam logic signed [3:0] STEP_TABLE [16] = '{
     4'sd0, -4'sd1,  4'sd1,  4'sd0,
     4'sd1,  4'sd0,  4'sd0, -4'sd1,
    -4'sd1,  4'sd0,  4'sd0,  4'sd1,
     4'sd0,  4'sd1, -4'sd1,  4'sd0
  };

  // Encoder status towards the result stage
  typedef struct packed {
    logic cw;
    logic ccw;
  } enc_evt_t;

  // Button status towards the result stage
  typedef struct packed {
    logic click;
    logic long_press;
  } btn_evt_t;

endpackage

// ===== sv/rebd_if.sv =====
// ----------------------------------------------------------------------------
// rebd_if
// Request and result channels of the rotary encoder and button decoder.
// ----------------------------------------------------------------------------
interface rebd_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic        pin_a;
  logic        pin_b;
  logic        button_level;
  logic [31:0] time_us;
  logic [31:0] time_ms;

  modport source (output valid, mode, pin_a, pin_b, button_level, time_us, time_ms,
                  input ready);
  modport sink   (input valid, mode, pin_a, pin_b, button_level, time_us, time_ms,
                  output ready);
endinterface

interface rebd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;

  modport source (output valid, event_res, input ready);
  modport sink   (input valid, event_res, output ready);
endinterface

// ===== sv/rebd_quad.sv =====
// ----------------------------------------------------------------------------
// rebd_quad
// Quadrature phase tracking, sample spacing and detent accumulation.
// ----------------------------------------------------------------------------
module rebd_quad #(
  parameter int TIME_WIDTH       = 32,
  parameter int STEPS_PER_DETENT = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  mode,
  input  logic                  pin_a,
  input  logic                  pin_b,
  input  logic [TIME_WIDTH-1:0] now_us,
  input  logic [15:0]           enc_holdoff_us,
  output rebd_pkg::enc_evt_t    evt
);

  localparam logic signed [3:0] DETENT = 4'(STEPS_PER_DETENT);

  logic [3:0]            phase;
  logic [3:0]            phase_next;
  logic signed [3:0]     acc;
  logic signed [3:0]     acc_next;
  logic [TIME_WIDTH-1:0] last_sample;
  logic [TIME_WIDTH-1:0] last_sample_next;

  logic                  sample;
  logic [3:0]            phase_shift;
  logic signed [3:0]     acc_mid;
  logic                  hit_cw;
  logic                  hit_ccw;

  always_comb begin
    sample      = (now_us - last_sample) >= TIME_WIDTH'(enc_holdoff_us);
    phase_shift = {phase[1:0], pin_a, pin_b};
    acc_mid     = sample ? acc + rebd_pkg::STEP_TABLE[phase_shift] : acc;
    hit_cw      = acc_mid >= DETENT;
    hit_ccw     = acc_mid <= -DETENT;

    phase_next       = phase;
    acc_next         = acc;
    last_sample_next = last_sample;
    if (mode) begin
      // capture start phase only
      phase_next = {2'b00, pin_a, pin_b};
    end else begin
      if (sample) begin
        phase_next       = phase_shift;
        last_sample_next = now_us;
      end
      acc_next = (hit_cw || hit_ccw) ? 4'sd0 : acc_mid;
    end

    evt.cw  = !mode && hit_cw;
    evt.ccw = !mode && !hit_cw && hit_ccw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= '0;
      acc         <= '0;
      last_sample <= '0;
    end else if (en) begin
      phase       <= phase_next;
      acc         <= acc_next;
      last_sample <= last_sample_next;
    end
  end

endmodule

// ===== sv/rebd_button.sv =====
// ----------------------------------------------------------------------------
// rebd_button
// Button debounce, press timing, click and long press detection.
// ----------------------------------------------------------------------------
module rebd_button #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  mode,
  input  logic                  button_level,
  input  logic [TIME_WIDTH-1:0] now_ms,
  input  logic [15:0]           long_press_ms,
  input  logic [7:0]            btn_settle_ms,
  output rebd_pkg::btn_evt_t    evt
);

  logic                  last_level;
  logic                  last_level_next;
  logic [TIME_WIDTH-1:0] press_start;
  logic [TIME_WIDTH-1:0] press_start_next;
  logic [TIME_WIDTH-1:0] last_change;
  logic [TIME_WIDTH-1:0] last_change_next;

  logic                  change;
  logic [TIME_WIDTH-1:0] press_mid;
  logic                  click;
  logic                  long_hit;

  always_comb begin
    change = (button_level != last_level) &&
             ((now_ms - last_change) > TIME_WIDTH'(btn_settle_ms));

    // press start zero stands for no press
    click = change && button_level && (press_start != '0) &&
            ((now_ms - press_start) < TIME_WIDTH'(long_press_ms));
    if (change) begin
      press_mid = button_level ? '0 : now_ms;
    end else begin
      press_mid = press_start;
    end
    long_hit = (press_mid != '0) &&
               ((now_ms - press_mid) >= TIME_WIDTH'(long_press_ms));

    last_level_next  = last_level;
    last_change_next = last_change;
    press_start_next = press_start;
    if (!mode) begin
      if (change) begin
        last_level_next  = button_level;
        last_change_next = now_ms;
      end
      press_start_next = long_hit ? '0 : press_mid;
    end

    evt.click      = !mode && click;
    evt.long_press = !mode && long_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level  <= 1'b0;
      press_start <= '0;
      last_change <= '0;
    end else if (en) begin
      last_level  <= last_level_next;
      press_start <= press_start_next;
      last_change <= last_change_next;
    end
  end

endmodule

// ===== sv/rotary_encoder_button_decoder.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder: request register, then result register.
// Throughput one request per cycle while the sink is ready; the registers
// are separate stages; a held result still lets one request in. Reset (rst,
// synchronous, active high) restores config, clears valid and decoder state.
// ----------------------------------------------------------------------------
module rotary_encoder_button_decoder #(
  parameter int TIME_WIDTH       = 32,
  parameter int STEPS_PER_DETENT = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  rebd_in_if.sink                       in_ch,
  rebd_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [rebd_pkg::CFG_DATA_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers, no read-back; the user must write them only while
  // idle, the block does not enforce it. An index beyond the list is dropped.
  // --------------------------------------------------------------------------
  logic [15:0] long_press_ms;
  logic [15:0] enc_holdoff_us;
  logic [7:0]  btn_settle_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms  <= rebd_pkg::LONG_PRESS_MS_RST;
      enc_holdoff_us <= rebd_pkg::ENC_HOLDOFF_US_RST;
      btn_settle_ms  <= rebd_pkg::BTN_SETTLE_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rebd_pkg::CFG_LONG_PRESS_MS:  long_press_ms  <= cfg_data;
        rebd_pkg::CFG_ENC_HOLDOFF_US: enc_holdoff_us <= cfg_data;
        rebd_pkg::CFG_BTN_SETTLE_MS:  btn_settle_ms  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request register. The request is held here while the decoders evaluate
  // it against the current state; it advances into the result register
  // whenever that register is empty or being drained this cycle.
  // --------------------------------------------------------------------------
  logic                  req_valid;
  logic                  req_mode;
  logic                  req_pin_a;
  logic                  req_pin_b;
  logic                  req_button;
  logic [TIME_WIDTH-1:0] req_us;
  logic [TIME_WIDTH-1:0] req_ms;

  logic                  res_valid;
  rebd_pkg::event_t      res_event;

  logic                  advance;
  logic                  process;
  logic                  accept;

  assign advance     = !res_valid || out_ch.ready;
  assign process     = req_valid && advance;
  assign in_ch.ready = !req_valid || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (process) begin
      req_valid <= 1'b0;
    end
  end

  // Timestamps wrap at TIME_WIDTH bits; narrower widths drop the top bits.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode   <= in_ch.mode;
      req_pin_a  <= in_ch.pin_a;
      req_pin_b  <= in_ch.pin_b;
      req_button <= in_ch.button_level;
      req_us     <= TIME_WIDTH'(in_ch.time_us);
      req_ms     <= TIME_WIDTH'(in_ch.time_ms);
    end
  end

  // --------------------------------------------------------------------------
  // Decoders. Each updates its own state only when the request advances.
  // --------------------------------------------------------------------------
  rebd_pkg::enc_evt_t enc_evt;
  rebd_pkg::btn_evt_t btn_evt;

  rebd_quad #(
    .TIME_WIDTH       (TIME_WIDTH),
    .STEPS_PER_DETENT (STEPS_PER_DETENT)
  ) u_quad (
    .clk            (clk),
    .rst            (rst),
    .en             (process),
    .mode           (req_mode),
    .pin_a          (req_pin_a),
    .pin_b          (req_pin_b),
    .now_us         (req_us),
    .enc_holdoff_us (enc_holdoff_us),
    .evt            (enc_evt)
  );

  rebd_button #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_button (
    .clk           (clk),
    .rst           (rst),
    .en            (process),
    .mode          (req_mode),
    .button_level  (req_button),
    .now_ms        (req_ms),
    .long_press_ms (long_press_ms),
    .btn_settle_ms (btn_settle_ms),
    .evt           (btn_evt)
  );

  // --------------------------------------------------------------------------
  // Result merge: a button event overrides an encoder event, and a long
  // press overrides a click (both cannot fire together in practice).
  // --------------------------------------------------------------------------
  rebd_pkg::event_t res_event_next;

  always_comb begin
    priority if (btn_evt.long_press) begin
      res_event_next = rebd_pkg::EV_LONG;
    end else if (btn_evt.click) begin
      res_event_next = rebd_pkg::EV_CLICK;
    end else if (enc_evt.cw) begin
      res_event_next = rebd_pkg::EV_CW;
    end else if (enc_evt.ccw) begin
      res_event_next = rebd_pkg::EV_CCW;
    end else begin
      res_event_next = rebd_pkg::EV_NONE;
    end
  end

  // Result register: load on advance, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      res_event <= res_event_next;
    end
  end

  assign out_ch.valid     = res_valid;
  assign out_ch.event_res = res_event;

`ifndef SYNTHESIS
  // Stall only when both stages are full and the sink holds back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (req_valid && res_valid && !out_ch.ready))
    else $error("request side stalled without a full pipeline");

  // Phase capture never produces an event.
  a_capture_quiet: assert property (@(posedge clk) disable iff (rst)
    (process && req_mode) |=> (out_ch.event_res == rebd_pkg::EV_NONE))
    else $error("capture request produced an event");

  // Every processed request lands in the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    process |=> res_valid)
    else $error("processed request lost");
`endif

endmodule
